/* rtl/core/plc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package plc_pkg;

    // Geometry of the chaser
    localparam int LED_COUNT     = 8;
    localparam int DUTY_BITS     = 5;
    localparam int PHASE_W       = 3;
    localparam int LED_PATTERN_W = 8;
    localparam int TABLE_W       = LED_COUNT * DUTY_BITS;
    localparam int IDX_W         = $clog2(LED_COUNT);
    localparam int STEP_W        = 9;
    localparam int SPEED_W       = 8;
    localparam int DEB_W         = 8;
    localparam int FUNC_W        = 2;

    // Configuration port
    localparam int CFG_DATA_W = TABLE_W;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_TABLE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'b1;

    // Reset packs the levels 31, 20, 11, 7, 4, 2, 1, 0 with entry 0 lowest
    localparam logic [TABLE_W-1:0] TABLE_RESET    = 40'd1145286303;
    localparam logic [DEB_W-1:0]   DEBOUNCE_RESET = 8'd40;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PWM   = 2'd0,
        FUNC_SYS   = 2'd1,
        FUNC_SPEED = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    typedef struct packed {
        t_func              func;
        logic               button_level;
        logic [SPEED_W-1:0] speed_value;
    } t_item;

    typedef struct packed {
        logic [LED_PATTERN_W-1:0] led_pattern;
        logic                     reverse;
        logic [PHASE_W-1:0]       phase_now;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/plc_led_cmp.sv */
`timescale 1ns / 1ps
`default_nettype none

// Works out which LEDs are lit for a given duty count: one compare per LED.
module plc_led_cmp (
    input  wire logic [plc_pkg::TABLE_W-1:0]       i_table,
    input  wire logic [plc_pkg::DUTY_BITS:0]       i_count,
    input  wire logic [plc_pkg::PHASE_W-1:0]       i_phase,
    input  wire logic                              i_reverse,
    output logic      [plc_pkg::LED_PATTERN_W-1:0] o_pattern
);

    always_comb begin
        logic [plc_pkg::PHASE_W-1:0]   k;
        logic [plc_pkg::PHASE_W-1:0]   k_mod;
        logic [plc_pkg::DUTY_BITS-1:0] level;
        o_pattern = '0;
        for (int j = 0; j < plc_pkg::LED_COUNT; j++) begin
            if (i_reverse) begin
                k = i_phase - plc_pkg::PHASE_W'(j);
            end else begin
                k = i_phase + plc_pkg::PHASE_W'(j);
            end
            // k is below 8, which is below twice the LED count
            if (k >= plc_pkg::PHASE_W'(plc_pkg::LED_COUNT)) begin
                k_mod = k - plc_pkg::PHASE_W'(plc_pkg::LED_COUNT);
            end else begin
                k_mod = k;
            end
            level = i_table[k_mod[plc_pkg::IDX_W-1:0]*plc_pkg::DUTY_BITS +: plc_pkg::DUTY_BITS];
            o_pattern[j] = (i_count <= {1'b0, level});
        end
    end

endmodule

`default_nettype wire

/* rtl/core/plc_in_reg.sv */
`timescale 1ns / 1ps
`default_nettype none

// Input register: holds one accepted item until the state stage takes it.
module plc_in_reg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire plc_pkg::t_item i_item,
    input  wire logic           i_drain,
    output logic                o_valid,
    output plc_pkg::t_item      o_item
);

    logic           r_valid;
    plc_pkg::t_item r_item;

    assign o_ready = !r_valid || i_drain;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/plc_state.sv */
`timescale 1ns / 1ps
`default_nettype none

// Chaser state, configuration registers and the next-state logic for one item.
module plc_state (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_step,
    input  wire plc_pkg::t_item                     i_item,
    input  wire logic                               i_cfg_we,
    input  wire logic [plc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [plc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output plc_pkg::t_result                        o_next
);

    typedef enum logic [1:0] {
        MODE_WAIT_PRESS = 2'd0,
        MODE_PRESS_DLY  = 2'd1,
        MODE_WAIT_REL   = 2'd2,
        MODE_REL_DLY    = 2'd3
    } t_mode;

    logic [plc_pkg::TABLE_W-1:0]       r_table;
    logic [plc_pkg::DEB_W-1:0]         r_deb_ticks;
    logic [plc_pkg::DUTY_BITS-1:0]     r_duty,    n_duty;
    logic [plc_pkg::LED_PATTERN_W-1:0] r_leds,    n_leds;
    logic [plc_pkg::PHASE_W-1:0]       r_phase,   n_phase;
    logic                              r_dir,     n_dir;
    logic [plc_pkg::STEP_W-1:0]        r_step,    n_step;
    logic [plc_pkg::SPEED_W-1:0]       r_speed,   n_speed;
    t_mode                             r_mode,    n_mode;
    logic [plc_pkg::DEB_W-1:0]         r_count,   n_count;

    logic [plc_pkg::DUTY_BITS:0]       duty_inc;
    logic [plc_pkg::LED_PATTERN_W-1:0] pattern;
    logic [plc_pkg::STEP_W-1:0]        step_inc;
    logic [plc_pkg::DEB_W-1:0]         count_inc;
    logic                              deb_done;

    assign duty_inc  = {1'b0, r_duty} + 1'b1;
    assign step_inc  = r_step + 1'b1;
    assign count_inc = r_count + 1'b1;
    assign deb_done  = (count_inc >= r_deb_ticks);

    plc_led_cmp u_led_cmp (
        .i_table   (r_table),
        .i_count   (duty_inc),
        .i_phase   (r_phase),
        .i_reverse (r_dir),
        .o_pattern (pattern)
    );

    always_comb begin
        n_duty  = r_duty;
        n_leds  = r_leds;
        n_phase = r_phase;
        n_dir   = r_dir;
        n_step  = r_step;
        n_speed = r_speed;
        n_mode  = r_mode;
        n_count = r_count;
        case (i_item.func)
            plc_pkg::FUNC_PWM: begin
                n_leds = pattern;
                n_duty = duty_inc[plc_pkg::DUTY_BITS-1:0];
            end
            plc_pkg::FUNC_SYS: begin
                // Rotation step: the delay must exceed the speed before the phase moves
                if (step_inc > {1'b0, r_speed}) begin
                    n_phase = r_phase + 1'b1;
                    n_step  = '0;
                end else begin
                    n_step = step_inc;
                end
                unique case (r_mode)
                    MODE_WAIT_PRESS: begin
                        if (!i_item.button_level) begin
                            n_mode  = MODE_PRESS_DLY;
                            n_count = '0;
                        end
                    end
                    MODE_PRESS_DLY: begin
                        n_count = count_inc;
                        if (deb_done) begin
                            if (!i_item.button_level) begin
                                n_dir  = !r_dir;
                                n_mode = MODE_WAIT_REL;
                            end else begin
                                n_mode = MODE_WAIT_PRESS;
                            end
                        end
                    end
                    MODE_WAIT_REL: begin
                        if (i_item.button_level) begin
                            n_mode  = MODE_REL_DLY;
                            n_count = '0;
                        end
                    end
                    MODE_REL_DLY: begin
                        n_count = count_inc;
                        if (deb_done) begin
                            n_mode = i_item.button_level ? MODE_WAIT_PRESS : MODE_WAIT_REL;
                        end
                    end
                    default: begin
                        n_mode = MODE_WAIT_PRESS;
                    end
                endcase
            end
            plc_pkg::FUNC_SPEED: begin
                n_speed = i_item.speed_value;
            end
            default: begin
            end
        endcase
    end

    assign o_next.led_pattern = n_leds;
    assign o_next.reverse     = n_dir;
    assign o_next.phase_now   = n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table     <= plc_pkg::TABLE_RESET;
            r_deb_ticks <= plc_pkg::DEBOUNCE_RESET;
            r_duty      <= '0;
            r_leds      <= '0;
            r_phase     <= '0;
            r_dir       <= 1'b0;
            r_step      <= '0;
            r_speed     <= '0;
            r_mode      <= MODE_WAIT_PRESS;
            r_count     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    plc_pkg::REG_TABLE:    r_table     <= i_cfg_data;
                    plc_pkg::REG_DEBOUNCE: r_deb_ticks <= i_cfg_data[plc_pkg::DEB_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_step) begin
                r_duty  <= n_duty;
                r_leds  <= n_leds;
                r_phase <= n_phase;
                r_dir   <= n_dir;
                r_step  <= n_step;
                r_speed <= n_speed;
                r_mode  <= n_mode;
                r_count <= n_count;
            end
        end
    end

`ifndef SYNTHESIS
    // After each system tick the delay is at most the speed, so it never reaches 256.
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step[plc_pkg::STEP_W-1] == 1'b0)
        else $error("step delay out of range");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_dir) && $stable(r_duty)
                    && $stable(r_mode))
        else $error("state moved without an item");

    a_dir_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_dir) |-> $past(r_mode) == MODE_PRESS_DLY && r_mode == MODE_WAIT_REL)
        else $error("direction flipped outside a confirmed press");

    a_phase_sys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.func != plc_pkg::FUNC_SYS |=> $stable(r_phase))
        else $error("phase moved on a non-system item");
`endif

endmodule

`default_nettype wire

/* rtl/core/pwm_led_chaser_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake                  | Payload
// ----------+----------------------------+------------------------------------------
// input     | i_in_valid / o_in_ready    | i_func, i_button_level, i_speed_value
// result    | o_out_valid / i_out_ready  | o_led_pattern, o_reverse, o_phase_now
// config    | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// A transfer in is loaded into the input register, where the state update works on it,
// and its result is then loaded into the result register, from which the result
// transfer is made.
// One item is taken every cycle when the result side keeps up; the state update
// for one item is the only recurrence, from the state registers back to them.
// Reset is synchronous and active low; it restores the state and both valid flags.
// A stalled result holds the state stage; the input register takes one further
// transfer only while it is empty, and o_in_ready falls once it holds an item.
module pwm_led_chaser_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [plc_pkg::FUNC_W-1:0]          i_func,
    input  wire logic                                i_button_level,
    input  wire logic [plc_pkg::SPEED_W-1:0]         i_speed_value,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic      [plc_pkg::LED_PATTERN_W-1:0]   o_led_pattern,
    output logic                                     o_reverse,
    output logic      [plc_pkg::PHASE_W-1:0]         o_phase_now,
    input  wire logic                                i_cfg_we,
    input  wire logic [plc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [plc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    plc_pkg::t_item   in_item;
    plc_pkg::t_item   held_item;
    plc_pkg::t_result next_result;
    logic             held_valid;
    logic             out_free;
    logic             advance;

    logic             r_out_valid;
    plc_pkg::t_result r_result;

    assign in_item.func         = plc_pkg::t_func'(i_func);
    assign in_item.button_level = i_button_level;
    assign in_item.speed_value  = i_speed_value;

    // The result register can take a new value when it is empty or is being
    // emptied by a transfer in this cycle.
    assign out_free = !r_out_valid || i_out_ready;
    assign advance  = held_valid && out_free;

    plc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .i_drain (out_free),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    // The state stage applies the held item and offers the state as it will
    // stand afterwards, which is exactly what the result reports.
    plc_state u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_item     (held_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_next     (next_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= held_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= next_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_led_pattern = r_result.led_pattern;
    assign o_reverse     = r_result.reverse;
    assign o_phase_now   = r_result.phase_now;

endmodule

`default_nettype wire

/* tb/pwm_led_chaser_core_tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the eight-LED PWM chaser core.
//
// Items go in over the valid/ready input channel and every transfer in gives exactly one
// result transfer out. A model of the chaser held in this module advances its own copy of
// the state at each input transfer and queues the result it expects; each result transfer
// is checked field by field against the oldest entry of that queue.
//
// The run opens with a short table of directed items under the reset register values,
// then walks through several register settings (random, all-ones and all-zero tables,
// debounce lengths of zero, one, two, three, forty and 255). Registers are only written
// once the core has drained. Button stimulus is mostly held levels long enough for the
// debounce machine to confirm, with the odd glitch thrown in.
module pwm_led_chaser_core_tb;

    localparam int LIMIT_IDLE   = 2000;  // cycles without any transfer before giving up
    localparam int LONG_HOLD    = 250;   // one long result-side hold-off
    localparam int HOLD_AFTER   = 400;   // input transfers before that hold-off starts
    localparam int NUM_PHASES   = 6;
    localparam int PHASE_ITEMS [NUM_PHASES] = '{230, 230, 180, 140, 700, 150};
    // Share of system ticks in percent; the long debounce phase needs plenty of them.
    localparam int SYS_SHARE   [NUM_PHASES] = '{45, 55, 45, 45, 80, 50};

    typedef enum logic [1:0] {
        DB_WAIT_PRESS,
        DB_PRESS_DELAY,
        DB_WAIT_RELEASE,
        DB_RELEASE_DELAY
    } t_db_mode;

    // One directed item. Where fixed is set, the expected result is the one typed in.
    typedef struct packed {
        plc_pkg::t_func              func;
        logic                        level;
        logic [plc_pkg::SPEED_W-1:0] speed;
        logic                        fixed;
        plc_pkg::t_result            want;
    } t_row;

    localparam plc_pkg::t_result UNFIXED = '0;

    localparam int NUM_ROWS = 22;
    localparam t_row DIRECTED_ROWS [NUM_ROWS] = '{
        // Straight after reset everything reads zero.
        '{plc_pkg::FUNC_NOP,   1'b1, 8'h00, 1'b1, '{8'h00, 1'b0, 3'd0}},
        // First PWM tick: count 1 lights every LED whose level is at least 1.
        '{plc_pkg::FUNC_PWM,   1'b1, 8'h00, 1'b1, '{8'h7f, 1'b0, 3'd0}},
        '{plc_pkg::FUNC_SPEED, 1'b0, 8'hff, 1'b1, '{8'h7f, 1'b0, 3'd0}},
        // Slowest speed: one system tick does not rotate.
        '{plc_pkg::FUNC_SYS,   1'b1, 8'h00, 1'b1, '{8'h7f, 1'b0, 3'd0}},
        // Speed lowered below the running step delay, so the next tick rotates.
        '{plc_pkg::FUNC_SPEED, 1'b1, 8'h00, 1'b1, '{8'h7f, 1'b0, 3'd0}},
        '{plc_pkg::FUNC_SYS,   1'b1, 8'haa, 1'b1, '{8'h7f, 1'b0, 3'd1}},
        '{plc_pkg::FUNC_PWM,   1'b0, 8'h55, 1'b0, UNFIXED},
        // Unused function code with junk in the other fields.
        '{plc_pkg::FUNC_NOP,   1'b0, 8'h55, 1'b0, UNFIXED},
        '{plc_pkg::FUNC_SPEED, 1'b1, 8'h55, 1'b0, UNFIXED},
        '{plc_pkg::FUNC_SYS,   1'b0, 8'h00, 1'b0, UNFIXED},
        '{plc_pkg::FUNC_SYS,   1'b1, 8'hff, 1'b0, UNFIXED},
        '{plc_pkg::FUNC_SYS,   1'b0, 8'h00, 1'b0, UNFIXED},
        '{plc_pkg::FUNC_SPEED, 1'b0, 8'haa, 1'b0, UNFIXED},
        '{plc_pkg::FUNC_PWM,   1'b1, 8'h00, 1'b0, UNFIXED},
        '{plc_pkg::FUNC_PWM,   1'b0, 8'hff, 1'b0, UNFIXED},
        '{plc_pkg::FUNC_SYS,   1'b1, 8'h00, 1'b0, UNFIXED},
        '{plc_pkg::FUNC_NOP,   1'b1, 8'hff, 1'b0, UNFIXED},
        '{plc_pkg::FUNC_PWM,   1'b1, 8'h00, 1'b0, UNFIXED},
        '{plc_pkg::FUNC_SYS,   1'b0, 8'h00, 1'b0, UNFIXED},
        '{plc_pkg::FUNC_SPEED, 1'b0, 8'h01, 1'b0, UNFIXED},
        '{plc_pkg::FUNC_SYS,   1'b0, 8'h00, 1'b0, UNFIXED},
        '{plc_pkg::FUNC_PWM,   1'b0, 8'h00, 1'b0, UNFIXED}
    };

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_ready;
    logic [plc_pkg::FUNC_W-1:0]        i_func;
    logic                              i_button_level;
    logic [plc_pkg::SPEED_W-1:0]       i_speed_value;
    logic                              o_out_valid;
    logic                              i_out_ready;
    logic [plc_pkg::LED_PATTERN_W-1:0] o_led_pattern;
    logic                              o_reverse;
    logic [plc_pkg::PHASE_W-1:0]       o_phase_now;
    logic                              i_cfg_we;
    logic [plc_pkg::CFG_IDX_W-1:0]     i_cfg_idx;
    logic [plc_pkg::CFG_DATA_W-1:0]    i_cfg_data;

    pwm_led_chaser_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_button_level (i_button_level),
        .i_speed_value  (i_speed_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_led_pattern  (o_led_pattern),
        .o_reverse      (o_reverse),
        .o_phase_now    (o_phase_now),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    // Our own copy of the chaser: registers first, then the state.
    logic [plc_pkg::TABLE_W-1:0]       cfg_table;
    logic [plc_pkg::DEB_W-1:0]         cfg_deb;
    logic [plc_pkg::DUTY_BITS-1:0]     duty_cnt;
    logic [plc_pkg::LED_PATTERN_W-1:0] leds_q;
    logic [plc_pkg::PHASE_W-1:0]       phase_q;
    logic                              rev_q;
    logic [plc_pkg::STEP_W-1:0]        delay_q;
    logic [plc_pkg::SPEED_W-1:0]       speed_q;
    t_db_mode                          deb_mode;
    logic [plc_pkg::DEB_W-1:0]         deb_cnt;

    plc_pkg::t_result chaser_due_q [$];   // expected results, oldest first
    logic             fixed_known;        // the item on offer carries a typed-in result
    plc_pkg::t_result fixed_result;

    int  mismatches     = 0;
    int  accepted_items = 0;
    int  results_seen   = 0;
    int  dir_flips      = 0;
    int  phase_steps    = 0;
    bit  tail_quiet     = 1'b0;  // no idling on either side from here on

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Advances the chaser copy by one item and returns the result it then shows.
    function automatic plc_pkg::t_result advance_chaser(input plc_pkg::t_func f,
                                                        input logic lvl,
                                                        input logic [plc_pkg::SPEED_W-1:0] spd);
        logic [plc_pkg::DUTY_BITS:0]       c;
        logic [plc_pkg::PHASE_W-1:0]       k;
        logic [plc_pkg::LED_PATTERN_W-1:0] lit;
        plc_pkg::t_result                  r;
        case (f)
            plc_pkg::FUNC_PWM: begin
                // The counter runs 1..32 for the compare, so a level of 31 is never
                // lit on the last slot of the period.
                c   = {1'b0, duty_cnt} + 1'b1;
                lit = '0;
                for (int j = 0; j < plc_pkg::LED_COUNT; j++) begin
                    k = rev_q ? phase_q - plc_pkg::PHASE_W'(j)
                              : phase_q + plc_pkg::PHASE_W'(j);
                    if (c <= cfg_table[(k % plc_pkg::LED_COUNT) * plc_pkg::DUTY_BITS
                                       +: plc_pkg::DUTY_BITS])
                        lit[j] = 1'b1;
                end
                leds_q   = lit;
                duty_cnt = c[plc_pkg::DUTY_BITS-1:0];
            end
            plc_pkg::FUNC_SYS: begin
                delay_q = delay_q + 1'b1;
                if (delay_q > {1'b0, speed_q}) begin
                    phase_q = phase_q + 1'b1;
                    delay_q = '0;
                    phase_steps++;
                end
                // A debounce length of zero acts as one, since the count is
                // incremented before it is compared.
                case (deb_mode)
                    DB_WAIT_PRESS: begin
                        if (!lvl) begin
                            deb_mode = DB_PRESS_DELAY;
                            deb_cnt  = '0;
                        end
                    end
                    DB_PRESS_DELAY: begin
                        deb_cnt = deb_cnt + 1'b1;
                        if (deb_cnt >= cfg_deb) begin
                            if (!lvl) begin
                                rev_q    = ~rev_q;
                                deb_mode = DB_WAIT_RELEASE;
                                dir_flips++;
                            end else begin
                                deb_mode = DB_WAIT_PRESS;
                            end
                        end
                    end
                    DB_WAIT_RELEASE: begin
                        if (lvl) begin
                            deb_mode = DB_RELEASE_DELAY;
                            deb_cnt  = '0;
                        end
                    end
                    default: begin
                        deb_cnt = deb_cnt + 1'b1;
                        if (deb_cnt >= cfg_deb)
                            deb_mode = lvl ? DB_WAIT_PRESS : DB_WAIT_RELEASE;
                    end
                endcase
            end
            plc_pkg::FUNC_SPEED: speed_q = spd;
            default: ;  // the unused code only reports the state
        endcase
        r.led_pattern = leds_q;
        r.reverse     = rev_q;
        r.phase_now   = phase_q;
        return r;
    endfunction

    // Everything is sampled at the rising edge, where the inputs driven at the falling
    // edge are settled and the outputs still hold their pre-edge values. The expectation
    // is queued before the result side is looked at; with the input and result registers
    // between an item and its result the order does not matter, but keeps the queue honest.
    always @(posedge i_clk) begin : result_check
        plc_pkg::t_result want;
        plc_pkg::t_result got;
        if (!i_rst_n) begin
            cfg_table = plc_pkg::TABLE_RESET;
            cfg_deb   = plc_pkg::DEBOUNCE_RESET;
            duty_cnt  = '0;
            leds_q    = '0;
            phase_q   = '0;
            rev_q     = 1'b0;
            delay_q   = '0;
            speed_q   = '0;
            deb_mode  = DB_WAIT_PRESS;
            deb_cnt   = '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == plc_pkg::REG_TABLE)
                    cfg_table = i_cfg_data[plc_pkg::TABLE_W-1:0];
                else if (i_cfg_idx == plc_pkg::REG_DEBOUNCE)
                    cfg_deb = i_cfg_data[plc_pkg::DEB_W-1:0];
            end
            if (i_in_valid && o_in_ready) begin
                want = advance_chaser(plc_pkg::t_func'(i_func), i_button_level,
                                      i_speed_value);
                if (fixed_known)
                    want = fixed_result;
                chaser_due_q.push_back(want);
                accepted_items++;
            end
            if (o_out_valid && i_out_ready) begin
                got.led_pattern = o_led_pattern;
                got.reverse     = o_reverse;
                got.phase_now   = o_phase_now;
                results_seen++;
                if (chaser_due_q.size() == 0) begin
                    $error("result transfer with nothing expected: led_pattern %02h",
                           got.led_pattern);
                    mismatches++;
                end else begin
                    want = chaser_due_q.pop_front();
                    if (got.led_pattern !== want.led_pattern) begin
                        $error("led_pattern: expected %02h, actual %02h",
                               want.led_pattern, got.led_pattern);
                        mismatches++;
                    end
                    if (got.reverse !== want.reverse) begin
                        $error("reverse: expected %0b, actual %0b", want.reverse, got.reverse);
                        mismatches++;
                    end
                    if (got.phase_now !== want.phase_now) begin
                        $error("phase_now: expected %0d, actual %0d",
                               want.phase_now, got.phase_now);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Gives up when neither channel has seen a transfer for too long.
    always @(posedge i_clk) begin : watchdog
        int quiet_cycles;
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= LIMIT_IDLE) begin
                $display("watchdog: %0d cycles without a transfer", quiet_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Result side. Ready comes in runs, broken by short random stalls, and once by a
    // long hold-off so that the core fills up and drops o_in_ready while items are
    // still being offered.
    initial begin : result_side
        int span;
        bit long_hold_done;
        i_out_ready    = 1'b0;
        long_hold_done = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (!long_hold_done && accepted_items >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                i_out_ready   <= 1'b0;
                span           = LONG_HOLD;
            end else if (!tail_quiet && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                span         = $urandom_range(1, 10);
            end else begin
                i_out_ready <= 1'b1;
                span         = $urandom_range(1, 40);
            end
            repeat (span) @(negedge i_clk);
        end
    end

    // Offers one item from a falling edge and returns at the falling edge after its
    // transfer. Valid stays high into the next item when no gap is inserted.
    task automatic offer(input plc_pkg::t_func f, input logic lvl,
                         input logic [plc_pkg::SPEED_W-1:0] spd, input bit gaps_on);
        if (gaps_on && !tail_quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_func         <= f;
        i_button_level <= lvl;
        i_speed_value  <= spd;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Waits until every expected result has come back, then lets the pipeline settle
    // before anything else happens.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (chaser_due_q.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Writes both registers back to back, the table first.
    task automatic set_config(input logic [plc_pkg::TABLE_W-1:0] tbl,
                              input logic [plc_pkg::DEB_W-1:0] deb);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= plc_pkg::REG_TABLE;
        i_cfg_data <= tbl;
        @(negedge i_clk);
        i_cfg_idx  <= plc_pkg::REG_DEBOUNCE;
        i_cfg_data <= plc_pkg::CFG_DATA_W'(deb);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Random items. The button is mostly held long enough for the debounce machine to
    // confirm a press or release; some holds are cut short and the odd system tick
    // sees a glitch. Speeds are mostly small so that the phase keeps rotating.
    task automatic random_phase(input int count, input int sys_share);
        logic                        held;
        int                          hold_left;
        int                          deb_len;
        int                          pick;
        bit                          gaps_on;
        plc_pkg::t_func              f;
        logic                        lvl;
        logic [plc_pkg::SPEED_W-1:0] spd;
        held      = 1'b1;
        hold_left = 1;
        gaps_on   = 1'b1;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0)
                gaps_on = ($urandom_range(0, 2) != 0);
            deb_len = (cfg_deb == 0) ? 1 : int'(cfg_deb);
            if ($urandom_range(0, 99) < sys_share) begin
                f   = plc_pkg::FUNC_SYS;
                lvl = held;
                if ($urandom_range(0, 19) == 0)
                    lvl = ~held;
                hold_left--;
                if (hold_left <= 0) begin
                    held = ~held;
                    if ($urandom_range(0, 3) != 0)
                        hold_left = $urandom_range(deb_len + 1, 2 * deb_len + 3);
                    else
                        hold_left = $urandom_range(1, deb_len + 1);
                end
            end else begin
                lvl  = 1'($urandom_range(0, 1));
                pick = $urandom_range(0, 19);
                if (pick < 15)
                    f = plc_pkg::FUNC_PWM;
                else if (pick < 18)
                    f = plc_pkg::FUNC_SPEED;
                else
                    f = plc_pkg::FUNC_NOP;
            end
            if ($urandom_range(0, 9) < 7)
                spd = plc_pkg::SPEED_W'($urandom_range(0, 6));
            else
                spd = plc_pkg::SPEED_W'($urandom_range(0, 255));
            offer(f, lvl, spd, gaps_on);
        end
    endtask

    initial begin : stimulus
        logic [63:0] rnd;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_func         = plc_pkg::FUNC_NOP;
        i_button_level = 1'b1;
        i_speed_value  = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = plc_pkg::REG_TABLE;
        i_cfg_data     = '0;
        fixed_known    = 1'b0;
        fixed_result   = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed items under the reset register values.
        for (int n = 0; n < NUM_ROWS; n++) begin
            fixed_known  = DIRECTED_ROWS[n].fixed;
            fixed_result = DIRECTED_ROWS[n].want;
            offer(DIRECTED_ROWS[n].func, DIRECTED_ROWS[n].level, DIRECTED_ROWS[n].speed,
                  1'b1);
        end
        fixed_known = 1'b0;

        // The first random phase keeps the reset values; each later one starts from an
        // idle core with a fresh table and debounce length.
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p != 0) begin
                drain();
                rnd = {$urandom(), $urandom()};
                case (p)
                    1: set_config(rnd[plc_pkg::TABLE_W-1:0], 8'd3);
                    2: set_config({plc_pkg::TABLE_W{1'b1}}, 8'd1);
                    3: set_config('0, 8'd0);
                    4: set_config(rnd[plc_pkg::TABLE_W-1:0], 8'd255);
                    default: set_config(rnd[plc_pkg::TABLE_W-1:0], 8'd2);
                endcase
            end
            if (p == NUM_PHASES - 1)
                tail_quiet = 1'b1;
            random_phase(PHASE_ITEMS[p], SYS_SHARE[p]);
        end

        drain();
        repeat (10) @(posedge i_clk);

        $display("Covered %0d transfers in and %0d out over six register settings,",
                 accepted_items, results_seen);
        $display("with %0d direction changes and %0d phase steps along the way.",
                 dir_flips, phase_steps);
        if (mismatches == 0 && chaser_due_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
